FILE: rtl/core/sliding_window_ring_cache_core_macros.svh
// Assertion helpers for the ring cache checker.
`ifndef SLIDING_WINDOW_RING_CACHE_CORE_MACROS_SVH
`define SLIDING_WINDOW_RING_CACHE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, disabled during reset.
`define SWRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swrc assertion failed");

// Next-cycle implication, sampled on clk_i, disabled during reset.
`define SWRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swrc assertion failed");

`endif

FILE: rtl/core/swrc_pkg.sv
`default_nettype none
package swrc_pkg;
  localparam int unsigned DEPTH_DEF = 4096;
  localparam int unsigned CAP_W     = 13;
  localparam int unsigned OFF_W     = 48;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned REM_W     = CAP_W + 1;
  localparam logic [CAP_W-1:0] CAP_RST = 13'd4096;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OUTSIDE  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;
endpackage
`default_nettype wire

FILE: rtl/core/swrc_ram.sv
`default_nettype none
module swrc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/core/swrc_mod.sv
`default_nettype none
module swrc_mod
  import swrc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [OFF_W-1:0] dividend_i,
  input  wire logic [CAP_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [REM_W-1:0] rem_o
);
  localparam int unsigned CNT_W = $clog2(OFF_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [OFF_W-1:0] dvd_q, dvd_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [REM_W-1:0] shifted;

  assign shifted = {rem_q[REM_W-2:0], dvd_q[OFF_W-1]};
  assign done_o  = busy_q && (cnt_q == '0);
  assign rem_o   = rem_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(OFF_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        dvd_d = {dvd_q[OFF_W-2:0], 1'b0};
        rem_d = (shifted >= {1'b0, divisor_i}) ? shifted - {1'b0, divisor_i} : shifted;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end
endmodule
`default_nettype wire

FILE: rtl/core/sliding_window_ring_cache_core.sv
// Sliding-window ring cache.
// Input stream s_axis: one transaction per item; tuser carries the opcode
// (write byte, read byte, clear window), tdata the offset, length, position
// and write data. Output stream m_axis: exactly one result transaction per
// input item, tuser the status, tdata the read byte and the window state
// after the item.
// Capacity is written through capacity_we_i/capacity_i; the user must do so
// only while idle, and the block itself does not enforce this. Each accepted
// item is evaluated and its result loaded into the output register; a valid
// write at position 0 first runs the window-update states S_WIN1 to S_WIN4,
// and every valid write runs the window-check state S_CHK. A stored write or
// a read adds the offset modulo capacity, a 48-step restoring remainder unit,
// and a read then fetches the byte from the store. One item is in flight at
// a time; the next is accepted in the cycle after the result is loaded.
// Reset and any capacity write drop the window and run a clearing pass over
// all DEPTH store entries (4096 by default) with s_axis_tready
// low. The result sits in an output register: the next item is accepted
// while it waits, and a stalled receiver only blocks the following result.
`default_nettype none
module sliding_window_ring_cache_core
  import swrc_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         capacity_we_i,
  input  wire logic [12:0]  capacity_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // base_offset[47:0], total_length[79:48], byte_position[111:80], write_byte[119:112]
  input  wire logic [119:0] s_axis_tdata,
  // opcode[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // read_byte[7:0], window_valid[8], window_first[56:9], window_last[104:57],
  // window_size[117:105], zero[119:118]
  output logic [119:0]      m_axis_tdata,
  // status[1:0]
  output logic [1:0]        m_axis_tuser
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [11:0] {
    S_CLR  = 12'b000000000001,
    S_IDLE = 12'b000000000010,
    S_EVAL = 12'b000000000100,
    S_WIN1 = 12'b000000001000,
    S_WIN2 = 12'b000000010000,
    S_WIN3 = 12'b000000100000,
    S_WIN4 = 12'b000001000000,
    S_CHK  = 12'b000010000000,
    S_MODS = 12'b000100000000,
    S_MODW = 12'b001000000000,
    S_RD   = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [CAP_W-1:0] cap_q;
  logic             has_q, has_d;
  logic [OFF_W-1:0] start_q, start_d, end_q, end_d;

  opcode_e          op_q, op_d;
  logic [OFF_W-1:0] off_q, off_d, abs_q, abs_d, wrend_q, wrend_d;
  logic [LEN_W-1:0] len_q, len_d, pos_q, pos_d;
  logic [7:0]       wb_q, wb_d, rd_q, rd_d;
  status_e          st_q, st_d;

  logic             ov_q, ov_d;
  status_e          ost_q, ost_d;
  logic [7:0]       ord_q, ord_d;
  logic             ohas_q, ohas_d;
  logic [OFF_W-1:0] ofirst_q, ofirst_d, olast_q, olast_d;
  logic [CAP_W-1:0] osize_q, osize_d;

  logic [CAP_W-1:0] eff_cap;
  logic [OFF_W:0]   sum_len, sum_pos, cap_bound, cap_ext;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic             mod_start, mod_done;
  logic [REM_W-1:0] mod_rem;

  assign eff_cap   = ({8'd0, cap_q} > 21'(DEPTH)) ? CAP_W'(DEPTH) : cap_q;
  assign cap_ext   = (OFF_W+1)'(eff_cap);
  assign sum_len   = {1'b0, off_q} + (OFF_W+1)'(len_q);
  assign sum_pos   = {1'b0, off_q} + (OFF_W+1)'(pos_q);
  assign cap_bound = {1'b0, start_q} + cap_ext;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = ost_q;
  assign m_axis_tdata  = {2'b00, osize_q, olast_q, ofirst_q, ohas_q, ord_q};
  assign mod_start     = (state_q == S_MODS);

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    has_d    = has_q;
    start_d  = start_q;
    end_d    = end_q;
    op_d     = op_q;
    off_d    = off_q;
    len_d    = len_q;
    pos_d    = pos_q;
    wb_d     = wb_q;
    abs_d    = abs_q;
    wrend_d  = wrend_q;
    rd_d     = rd_q;
    st_d     = st_q;
    ov_d     = ov_q && !m_axis_tready;
    ost_d    = ost_q;
    ord_d    = ord_q;
    ohas_d   = ohas_q;
    ofirst_d = ofirst_q;
    olast_d  = olast_q;
    osize_d  = osize_q;
    ram_we    = 1'b0;
    ram_addr  = AW'(mod_rem);
    ram_wdata = wb_q;

    unique case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = opcode_e'(s_axis_tuser);
          off_d   = s_axis_tdata[47:0];
          len_d   = s_axis_tdata[79:48];
          pos_d   = s_axis_tdata[111:80];
          wb_d    = s_axis_tdata[119:112];
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        rd_d    = '0;
        st_d    = ST_OUTSIDE;
        abs_d   = sum_pos[OFF_W-1:0];
        wrend_d = sum_len[OFF_W-1:0];
        state_d = S_OUT;
        unique case (op_q)
          OP_CLEAR: begin
            has_d   = 1'b0;
            start_d = '0;
            end_d   = '0;
            st_d    = ST_OK;
          end
          OP_WRITE, OP_READ: begin
            if (sum_len[OFF_W]) begin
              st_d = ST_OVERFLOW;
            end else if (op_q == OP_WRITE) begin
              if (eff_cap != '0 && len_q != '0 && pos_q < len_q) begin
                state_d = (pos_q == '0) ? S_WIN1 : S_CHK;
              end
            end else if (len_q == '0) begin
              st_d = ST_OK;
            end else if (eff_cap != '0 && has_q && pos_q < len_q &&
                         off_q >= start_q && sum_len[OFF_W-1:0] <= end_q) begin
              state_d = S_MODS;
            end
          end
          default: begin
            st_d = ST_OUTSIDE;
          end
        endcase
      end
      S_WIN1: begin
        if (!has_q) begin
          has_d   = 1'b1;
          start_d = ((OFF_W+1)'(len_q) > cap_ext) ? wrend_q - OFF_W'(eff_cap) : off_q;
          end_d   = start_d;
        end
        state_d = S_WIN2;
      end
      S_WIN2: begin
        if ({1'b0, wrend_q} > cap_bound) begin
          start_d = wrend_q - OFF_W'(eff_cap);
        end
        state_d = S_WIN3;
      end
      S_WIN3: begin
        if (wrend_q > end_q) begin
          end_d = wrend_q;
        end
        state_d = S_WIN4;
      end
      S_WIN4: begin
        if ((end_q - start_q) > OFF_W'(eff_cap)) begin
          start_d = end_q - OFF_W'(eff_cap);
        end
        state_d = S_CHK;
      end
      S_CHK: begin
        state_d = (has_q && abs_q >= start_q && abs_q < end_q) ? S_MODS : S_OUT;
      end
      S_MODS: begin
        state_d = S_MODW;
      end
      S_MODW: begin
        if (mod_done) begin
          if (op_q == OP_WRITE) begin
            ram_we  = 1'b1;
            st_d    = ST_OK;
            state_d = S_OUT;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        rd_d    = ram_rdata;
        st_d    = ST_OK;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d     = 1'b1;
          ost_d    = st_q;
          ord_d    = rd_q;
          ohas_d   = has_q;
          ofirst_d = has_q ? start_q : '0;
          olast_d  = has_q ? end_q : '0;
          osize_d  = (has_q && end_q > start_q) ? CAP_W'(end_q - start_q) : '0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (capacity_we_i) begin
      has_d   = 1'b0;
      start_d = '0;
      end_d   = '0;
      clr_d   = '0;
      state_d = S_CLR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      cap_q   <= CAP_RST;
      has_q   <= 1'b0;
      start_q <= '0;
      end_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (capacity_we_i) begin
        cap_q <= capacity_i;
      end
      has_q   <= has_d;
      start_q <= start_d;
      end_q   <= end_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    off_q    <= off_d;
    len_q    <= len_d;
    pos_q    <= pos_d;
    wb_q     <= wb_d;
    abs_q    <= abs_d;
    wrend_q  <= wrend_d;
    rd_q     <= rd_d;
    st_q     <= st_d;
    ost_q    <= ost_d;
    ord_q    <= ord_d;
    ohas_q   <= ohas_d;
    ofirst_q <= ofirst_d;
    olast_q  <= olast_d;
    osize_q  <= osize_d;
  end

  swrc_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (abs_q),
    .divisor_i  (eff_cap),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  swrc_ram #(
    .Width (8),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );
endmodule
`default_nettype wire

FILE: rtl/core/swrc_checker.sv
`default_nettype none
`include "sliding_window_ring_cache_core_macros.svh"
module swrc_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [119:0] m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser
);
  `SWRC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `SWRC_ASSERT_NOW(a_size_needs_window, m_axis_tvalid && m_axis_tdata[117:105] != 13'd0, m_axis_tdata[8])
  `SWRC_ASSERT_NOW(a_no_window_zero, m_axis_tvalid && !m_axis_tdata[8], m_axis_tdata[104:9] == 96'd0)
  `SWRC_ASSERT_NOW(a_err_no_data, m_axis_tvalid && m_axis_tuser != 2'd0, m_axis_tdata[7:0] == 8'd0)
endmodule

bind sliding_window_ring_cache_core swrc_checker u_swrc_checker (.*);
`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import swrc_pkg::*;

  localparam int unsigned STORE_DEPTH = 4096;
  localparam logic [47:0] OFF_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] wsize;
    logic [47:0] wlast;
    logic [47:0] wfirst;
    logic        wvalid;
    logic [7:0]  rd;
  } result_t;

  typedef struct {
    opcode_e     op;
    logic [47:0] off;
    logic [31:0] len;
    logic [31:0] pos;
    logic [7:0]  wb;
    logic        has_exp;
    result_t     exp;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic capacity_we_i = 1'b0;
  logic [12:0] capacity_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  always #6 clk_i = ~clk_i;

  sliding_window_ring_cache_core u_dut (
    .clk_i, .rst_ni, .capacity_we_i, .capacity_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // cache shadow
  logic [7:0]  shadow_store [STORE_DEPTH];
  logic        win_open;
  logic [63:0] win_lo, win_hi;
  logic [12:0] cap_reg;

  result_t pending_results[$];
  int errors = 0;
  int n_results = 0;
  int n_sent = 0;
  int n_reads_ok = 0;
  int n_writes_ok = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  function automatic void shadow_clear();
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    win_open = 1'b0;
    win_lo = '0;
    win_hi = '0;
  endfunction

  function automatic void slide_window(logic [63:0] off, logic [63:0] len,
                                       logic [63:0] cap);
    logic [63:0] wr_end, wr_start;
    wr_end = off + len;
    wr_start = (len > cap) ? wr_end - cap : off;
    if (!win_open) begin
      win_open = 1'b1;
      win_lo = wr_start;
      win_hi = wr_start;
    end
    if (wr_end > win_lo + cap) win_lo = wr_end - cap;
    if (wr_end > win_hi) win_hi = wr_end;
    if (win_hi - win_lo > cap) win_lo = win_hi - cap;
  endfunction

  function automatic result_t cache_step(stim_t s);
    result_t r;
    logic [63:0] cap, off, len, pos, a;
    cap = (cap_reg > STORE_DEPTH) ? 64'(STORE_DEPTH) : 64'(cap_reg);
    off = 64'(s.off);
    len = 64'(s.len);
    pos = 64'(s.pos);
    r = '0;
    r.status = ST_OUTSIDE;
    if (s.op == OP_WRITE || s.op == OP_READ) begin
      if (off + len > 64'(OFF_MAX)) begin
        r.status = ST_OVERFLOW;
      end else if (s.op == OP_WRITE) begin
        if (cap != 0 && len != 0 && pos < len) begin
          a = off + pos;
          if (pos == 0) slide_window(off, len, cap);
          if (win_open && a >= win_lo && a < win_hi) begin
            shadow_store[a % cap] = s.wb;
            r.status = ST_OK;
          end
        end
      end else begin
        if (len == 0) begin
          r.status = ST_OK;
        end else if (cap != 0 && win_open && pos < len && off >= win_lo &&
                     off + len <= win_hi) begin
          r.rd = shadow_store[(off + pos) % cap];
          r.status = ST_OK;
        end
      end
    end else if (s.op == OP_CLEAR) begin
      win_open = 1'b0;
      win_lo = '0;
      win_hi = '0;
      r.status = ST_OK;
    end
    r.wvalid = win_open;
    r.wfirst = win_open ? win_lo[47:0] : '0;
    r.wlast = win_open ? win_hi[47:0] : '0;
    r.wsize = (win_open && win_hi > win_lo) ? 13'(win_hi - win_lo) : '0;
    return r;
  endfunction

  task automatic send_item(stim_t s);
    result_t r;
    r = cache_step(s);
    if (s.has_exp && r != s.exp) begin
      $error("directed row: expected %h, predicted %h", s.exp, r);
      errors++;
    end
    if (r.status == ST_OK && s.op == OP_READ && s.len != 0) n_reads_ok++;
    if (r.status == ST_OK && s.op == OP_WRITE) n_writes_ok++;
    pending_results.push_back(r);
    n_sent++;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= s.op;
    s_axis_tdata <= {s.wb, s.pos, s.len, s.off};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [12:0] v);
    wait_drained();
    capacity_we_i <= 1'b1;
    capacity_i <= v;
    @(posedge clk_i);
    capacity_we_i <= 1'b0;
    cap_reg = v;
    shadow_clear();
  endtask

  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[117:0]};
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status); errors++;
        end
        if (got.rd !== want.rd) begin
          $error("read_byte: expected %h, actual %h", want.rd, got.rd); errors++;
        end
        if (got.wvalid !== want.wvalid) begin
          $error("window_valid: expected %b, actual %b", want.wvalid, got.wvalid); errors++;
        end
        if (got.wfirst !== want.wfirst) begin
          $error("window_first: expected %h, actual %h", want.wfirst, got.wfirst); errors++;
        end
        if (got.wlast !== want.wlast) begin
          $error("window_last: expected %h, actual %h", want.wlast, got.wlast); errors++;
        end
        if (got.wsize !== want.wsize) begin
          $error("window_size: expected %0d, actual %0d", want.wsize, got.wsize); errors++;
        end
      end
      if (m_axis_tdata[119:118] !== 2'b00) begin
        $error("tdata pad: expected 0, actual %b", m_axis_tdata[119:118]); errors++;
      end
    end
  end

  function automatic stim_t mk(opcode_e op, logic [47:0] off, logic [31:0] len,
                               logic [31:0] pos, logic [7:0] wb);
    stim_t s;
    s.op = op; s.off = off; s.len = len; s.pos = pos; s.wb = wb;
    s.has_exp = 1'b0; s.exp = '0;
    return s;
  endfunction

  function automatic stim_t mkx(opcode_e op, logic [47:0] off, logic [31:0] len,
                                logic [31:0] pos, logic [7:0] wb, result_t e);
    stim_t s;
    s = mk(op, off, len, pos, wb);
    s.has_exp = 1'b1;
    s.exp = e;
    return s;
  endfunction

  task automatic random_op(int unsigned cap);
    stim_t s;
    logic [47:0] off;
    logic [31:0] len;
    int unsigned k;
    k = $urandom_range(99);
    if (k < 45) begin
      len = $urandom_range(1, 24);
      off = (k < 40) ? 48'($urandom_range(0, 3 * cap + 50)) :
                       48'({$urandom, $urandom});
      for (int unsigned p = 0; p < len; p++) begin
        send_item(mk(OP_WRITE, off, len, p, 8'($urandom)));
        if ($urandom_range(99) < 3) break;
      end
    end else if (k < 80) begin
      s = mk(OP_READ, win_open ? 48'(win_lo) + 48'($urandom_range(0, 8)) :
             48'($urandom_range(0, 300)), 32'($urandom_range(0, 12)), 0, 8'($urandom));
      if (s.len != 0) s.pos = $urandom_range(0, s.len);
      send_item(s);
    end else if (k < 84) begin
      send_item(mk(OP_CLEAR, 48'({$urandom, $urandom}), $urandom, $urandom,
                   8'($urandom)));
    end else if (k < 87) begin
      send_item(mk(OP_NONE, 48'({$urandom, $urandom}), $urandom, $urandom,
                   8'($urandom)));
    end else begin
      s = mk(opcode_e'($urandom_range(0, 1)), 48'({$urandom, $urandom}), $urandom,
             $urandom, 8'($urandom));
      if ($urandom_range(1)) s.pos = $urandom_range(0, 4);
      send_item(s);
    end
  endtask

  initial begin
    stim_t rows[$];
    result_t none, ovf;
    int unsigned caps[6];
    none = '0; none.status = ST_OUTSIDE;
    ovf = '0; ovf.status = ST_OVERFLOW;
    caps = '{4096, 1, 8191, 0, 37, 256};
    cap_reg = CAP_RST;
    shadow_clear();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    rows.push_back(mkx(OP_READ, 0, 1, 0, 0, none));
    rows.push_back(mkx(OP_WRITE, 5, 0, 0, 8'hff, none));
    rows.push_back(mkx(OP_WRITE, 0, 4, 1, 8'h11, none));
    rows.push_back(mkx(OP_NONE, OFF_MAX, '1, '1, 8'hff, none));
    rows.push_back(mkx(OP_WRITE, OFF_MAX, 1, 0, 8'h5a, ovf));
    rows.push_back(mkx(OP_READ, OFF_MAX - 2, 32'hffff_ffff, 0, 0, ovf));
    rows.push_back(mkx(OP_READ, 3, 0, 7, 0, '0));
    for (int p = 0; p < 4; p++) rows.push_back(mk(OP_WRITE, 100, 4, p, 8'(8'ha0 + p)));
    rows.push_back(mk(OP_WRITE, 100, 4, 4, 8'hee));
    for (int p = 0; p < 4; p++) rows.push_back(mk(OP_READ, 100, 4, p, 0));
    rows.push_back(mk(OP_READ, 100, 4, 4, 0));
    rows.push_back(mk(OP_READ, 99, 2, 0, 0));
    rows.push_back(mk(OP_WRITE, 0, 5000, 0, 8'h77));
    rows.push_back(mk(OP_WRITE, 0, 5000, 4999, 8'h78));
    rows.push_back(mk(OP_WRITE, OFF_MAX - 8, 8, 7, 8'h01));
    rows.push_back(mkx(OP_CLEAR, 0, 0, 0, 0, '0));
    rows.push_back(mk(OP_WRITE, 10, 3, 2, 8'h33));
    foreach (rows[i]) send_item(rows[i]);

    for (int ph = 0; ph < 6; ph++) begin
      write_capacity(13'(caps[ph]));
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 72; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 72; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (ph == 4) begin
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_off_cycles <= 600;
      end
      while (n_sent < 1900 * (ph + 1) / 6) begin
        random_op((caps[ph] == 0 || caps[ph] > STORE_DEPTH) ? 64 : caps[ph]);
      end
    end
    wait_drained();
    $display("Covered %0d results over capacities 4096,1,8191,0,37,256;", n_results);
    $display("%0d stored writes, %0d filled reads, idle and long-stall phases.",
             n_writes_ok, n_reads_ok);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl/core
rtl/core/swrc_pkg.sv
rtl/core/swrc_ram.sv
rtl/core/swrc_mod.sv
rtl/core/sliding_window_ring_cache_core.sv
rtl/core/swrc_checker.sv
bench/testbench.sv
